/* rtl/nsr_pkg.sv */
// ----------------------------------------------------------------------------
// nsr_pkg: shared definitions for the Newton square root block
// Field widths, parameter defaults, the controller state type and the
// status word that the serial divider reports to the controller.
// ----------------------------------------------------------------------------
package nsr_pkg;

	// Fixed widths of the word fields.
	localparam int unsigned RADICAND_W = 32;
	localparam int unsigned ROOT_W     = 33;
	localparam int unsigned ITER_W     = 5;

	// The iteration count saturates at this value on the output.
	localparam int unsigned ITER_SAT   = 31;
	// Wide enough for any iteration count the parameter range allows.
	localparam int unsigned ITER_EXT_W = 6;

	// Parameter defaults.
	localparam int unsigned MAX_ITER_DEF      = 30;
	localparam int unsigned FRACTION_BITS_DEF = 16;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_DIV,
		S_UPD,
		S_HOLD
	} nsr_state_t;

	// Status of the serial divider.
	typedef struct packed {
		logic busy;   // a division is in progress
		logic last;   // the final quotient bit is produced this cycle
	} nsr_div_stat_t;

endpackage

/* rtl/nsr_div.sv */
// ----------------------------------------------------------------------------
// nsr_div: radix-2 serial divider
// Divides the radicand, scaled by two to the power of twice the fraction
// width, by the current estimate. One quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module nsr_div #(
	parameter int unsigned FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF,
	localparam int unsigned XW = nsr_pkg::RADICAND_W + FRACTION_BITS,
	localparam int unsigned CW = $clog2(XW + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [nsr_pkg::RADICAND_W-1:0]   radicand,
	input  logic [XW-1:0]                    divisor,
	output logic [XW-1:0]                    quotient,
	output nsr_pkg::nsr_div_stat_t           stat
);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [XW-1:0] rem_q;
	logic [XW-1:0] dvd_q;
	logic [XW-1:0] quo_q;

	logic [XW:0]   trial;
	logic [XW:0]   diff;
	logic          fits;

	// The top FRACTION_BITS dividend bits are below the divisor (the estimate
	// never drops below one), so they go straight into the remainder and
	// only XW quotient bits remain to be produced.
	assign trial = {rem_q, dvd_q[XW-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(XW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(XW - FRACTION_BITS){1'b0}},
				radicand[nsr_pkg::RADICAND_W-1 -: FRACTION_BITS]};
			dvd_q <= {radicand[nsr_pkg::RADICAND_W-FRACTION_BITS-1:0],
				{(2 * FRACTION_BITS){1'b0}}};
		end else if (busy_q) begin
			rem_q <= fits ? diff[XW-1:0] : trial[XW-1:0];
			dvd_q <= {dvd_q[XW-2:0], 1'b0};
			quo_q <= {quo_q[XW-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.last = busy_q && (cnt_q == CW'(1));

endmodule

/* rtl/newton_square_root.sv */
// ----------------------------------------------------------------------------
// newton_square_root: fixed-point square root by Newton (Heron) iteration
// Computes x = (x + a/x)/2 from x = 1.0 until the estimate repeats or the
// iteration limit is reached; a radicand of zero returns zero directly.
// ----------------------------------------------------------------------------
// Usage. One word enters on the input channel (in_valid, in_ready,
// radicand) and one word leaves on the output channel (out_valid,
// out_ready, root, iterations_used, converged) for each input word.
// The block works on one word at a time. in_ready is high while the
// controller is idle. In each Newton update the serial divider yields
// the XW = 32 + FRACTION_BITS quotient bits, one per cycle, and the
// update state then adds, halves and compares. A radicand of zero skips
// the divider and goes straight to the output stage. The next word is
// accepted right after the result is moved into the output register,
// so a finished result waiting on a stalled receiver holds up no more
// than the next one's completion. When the receiver stalls, the output
// register keeps its word and out_valid stays high. Reset clears the
// controller, the divider and out_valid.
// ----------------------------------------------------------------------------
module newton_square_root #(
	parameter int unsigned MAX_ITER      = nsr_pkg::MAX_ITER_DEF,
	parameter int unsigned FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [nsr_pkg::RADICAND_W-1:0]  radicand,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [nsr_pkg::ROOT_W-1:0]      root,
	output logic [nsr_pkg::ITER_W-1:0]      iterations_used,
	output logic                            converged
);

	// Estimate width: 32 integer bits cover the first update, which is
	// about half the radicand.
	localparam int unsigned XW = nsr_pkg::RADICAND_W + FRACTION_BITS;
	localparam int unsigned NW = $clog2(MAX_ITER + 1);
	localparam logic [XW-1:0] ONE = XW'(1) << FRACTION_BITS;
	// Iteration count reported when the limit is reached.
	localparam logic [nsr_pkg::ITER_W-1:0] ITER_AT_LIMIT =
		(MAX_ITER > nsr_pkg::ITER_SAT) ? nsr_pkg::ITER_W'(nsr_pkg::ITER_SAT)
		                               : nsr_pkg::ITER_W'(MAX_ITER);

	nsr_pkg::nsr_state_t state_q, state_d;

	logic [nsr_pkg::RADICAND_W-1:0] a_q;
	logic [XW-1:0]                  x_q;
	logic [NW-1:0]                  n_q;
	logic                           conv_q;

	logic                           out_valid_q;
	logic [nsr_pkg::ROOT_W-1:0]     root_q;
	logic [nsr_pkg::ITER_W-1:0]     iter_q;
	logic                           out_conv_q;

	logic                           div_start;
	logic [XW-1:0]                  quotient;
	nsr_pkg::nsr_div_stat_t         div_stat;

	logic [XW:0]                    sum;
	logic [XW-1:0]                  x_next;
	logic [NW-1:0]                  n_next;
	logic                           repeat_hit;
	logic                           limit_hit;
	logic                           accept;
	logic                           load_out;
	logic [nsr_pkg::ROOT_W-1:0]     root_sat;
	logic [nsr_pkg::ITER_W-1:0]     iter_sat;

	nsr_div #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.radicand (a_q),
		.divisor  (x_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// One Newton update: x' = floor((x + q) / 2). The sum keeps its carry.
	assign sum        = {1'b0, x_q} + {1'b0, quotient};
	assign x_next     = sum[XW:1];
	assign n_next     = n_q + 1'b1;
	assign repeat_hit = (x_next == x_q);
	assign limit_hit  = (n_next == NW'(MAX_ITER));

	assign accept = in_valid && in_ready;

	// Saturate the results to their field widths.
	assign root_sat = (x_q[XW-1:nsr_pkg::ROOT_W] != '0) ? '1 : x_q[nsr_pkg::ROOT_W-1:0];
	assign iter_sat =
		(nsr_pkg::ITER_EXT_W'(n_q) > nsr_pkg::ITER_EXT_W'(nsr_pkg::ITER_SAT))
			? nsr_pkg::ITER_W'(nsr_pkg::ITER_SAT) : nsr_pkg::ITER_W'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			nsr_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (radicand == '0) ? nsr_pkg::S_HOLD : nsr_pkg::S_START;
				end
			end
			nsr_pkg::S_START: begin
				div_start = 1'b1;
				state_d   = nsr_pkg::S_DIV;
			end
			nsr_pkg::S_DIV: begin
				if (div_stat.last) begin
					state_d = nsr_pkg::S_UPD;
				end
			end
			nsr_pkg::S_UPD: begin
				if (repeat_hit || limit_hit) begin
					state_d = nsr_pkg::S_HOLD;
				end else begin
					div_start = 1'b1;
					state_d   = nsr_pkg::S_DIV;
				end
			end
			nsr_pkg::S_HOLD: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = nsr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nsr_pkg::S_IDLE;
			end
		endcase
	end

	// Working registers of the current word.
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q    <= radicand;
			n_q    <= '0;
			x_q    <= (radicand == '0) ? '0 : ONE;
			conv_q <= (radicand == '0);
		end else if (state_q == nsr_pkg::S_UPD) begin
			x_q    <= x_next;
			n_q    <= n_next;
			conv_q <= repeat_hit;
		end
	end

	// Output register: frees the controller as soon as a result is stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			root_q     <= root_sat;
			iter_q     <= iter_sat;
			out_conv_q <= conv_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign root            = root_q;
	assign iterations_used = iter_q;
	assign converged       = out_conv_q;

	// The divider is never left running once the controller is idle.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nsr_pkg::S_IDLE) |-> !div_stat.busy)
		else $error("divider busy while the controller is idle");

	// Newton steps never bring the estimate below one, so no division by zero.
	a_est_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nsr_pkg::S_DIV) |-> (x_q >= ONE))
		else $error("estimate fell below one during a division");

	// Zero updates only happen for a zero radicand, which returns zero converged.
	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (iterations_used == '0)) |-> ((root == '0) && converged))
		else $error("word without updates is not a converged zero");

	// A word that did not converge used up the whole iteration budget.
	a_limit_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !converged) |-> (iterations_used == ITER_AT_LIMIT))
		else $error("unconverged word before the iteration limit");

endmodule

/* dv/nsr_root_monitor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nsr_root_monitor: scoreboard for the Newton square root block
// Watches both channels, works out the expected result word for every
// accepted radicand and compares each delivered word with the oldest one.
// ----------------------------------------------------------------------------
module nsr_root_monitor #(
	parameter int unsigned MAX_ITER      = nsr_pkg::MAX_ITER_DEF,
	parameter int unsigned FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [nsr_pkg::RADICAND_W-1:0]  radicand,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [nsr_pkg::ROOT_W-1:0]      root,
	input  logic [nsr_pkg::ITER_W-1:0]      iterations_used,
	input  logic                            converged,
	output int                              pending_count,
	output int                              fail_count
);

	typedef struct packed {
		logic [nsr_pkg::ROOT_W-1:0] root;
		logic [nsr_pkg::ITER_W-1:0] iters;
		logic                       conv;
	} root_word_t;

	root_word_t expected_roots[$];

	// Heron iteration in Q.FRACTION_BITS with a 128-bit dividend; the
	// quotient and the sum saturate to 64 bits.
	function automatic root_word_t heron_root(input logic [nsr_pkg::RADICAND_W-1:0] a);
		logic [127:0] dividend;
		logic [127:0] quot_wide;
		logic [63:0]  estimate;
		logic [63:0]  divisor;
		logic [63:0]  quot;
		logic [63:0]  next_est;
		logic [64:0]  sum;
		int unsigned  steps;
		logic         settled;
		root_word_t   res;
		steps   = 0;
		settled = 1'b0;
		if (a == '0) begin
			res.root  = '0;
			res.iters = '0;
			res.conv  = 1'b1;
			return res;
		end
		dividend = {96'b0, a} << (2 * FRACTION_BITS);
		estimate = 64'd1 << FRACTION_BITS;
		while (steps < MAX_ITER && !settled) begin
			divisor   = (estimate == '0) ? 64'd1 : estimate;
			quot_wide = dividend / {64'b0, divisor};
			quot      = (quot_wide[127:64] != '0) ? '1 : quot_wide[63:0];
			sum       = {1'b0, estimate} + {1'b0, quot};
			if (sum[64])
				next_est = {1'b0, {63{1'b1}}};
			else
				next_est = {1'b0, sum[63:1]};
			steps++;
			if (next_est == estimate)
				settled = 1'b1;
			estimate = next_est;
		end
		if (estimate > {31'b0, {nsr_pkg::ROOT_W{1'b1}}})
			res.root = '1;
		else
			res.root = estimate[nsr_pkg::ROOT_W-1:0];
		res.iters = (steps > nsr_pkg::ITER_SAT) ? nsr_pkg::ITER_W'(nsr_pkg::ITER_SAT)
			: nsr_pkg::ITER_W'(steps);
		res.conv  = settled;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int         errs;
		int         delta;
		root_word_t exp_word;
		if (!arst_n) begin
			expected_roots.delete();
			pending_count <= 0;
			fail_count    <= 0;
		end else begin
			errs  = 0;
			delta = 0;
			if (in_valid && in_ready) begin
				expected_roots.push_back(heron_root(radicand));
				delta++;
			end
			if (out_valid && out_ready) begin
				if (expected_roots.size() == 0) begin
					$display("%0t: result word with nothing expected: root %h iter %0d conv %0b",
						$time, root, iterations_used, converged);
					errs++;
				end else begin
					exp_word = expected_roots.pop_front();
					delta--;
					if (root !== exp_word.root) begin
						$display("%0t: root mismatch: expected %h, actual %h",
							$time, exp_word.root, root);
						errs++;
					end
					if (iterations_used !== exp_word.iters) begin
						$display("%0t: iterations_used mismatch: expected %0d, actual %0d",
							$time, exp_word.iters, iterations_used);
						errs++;
					end
					if (converged !== exp_word.conv) begin
						$display("%0t: converged mismatch: expected %0b, actual %0b",
							$time, exp_word.conv, converged);
						errs++;
					end
				end
			end
			pending_count <= pending_count + delta;
			fail_count    <= fail_count + errs;
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the Newton square root block
// Drives radicands with random gaps, stalls the result side at random and
// once for a long stretch, and reports the verdict from the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

	// Cycles without a word moving on either channel before the run is declared hung.
	// The slowest word and the long receiver hold-off of HOLD_OFF_CYCLES
	// both stay well below this limit, so it leaves a wide margin.
	localparam int unsigned WATCHDOG_LIMIT  = 40000;
	localparam int unsigned HOLD_OFF_CYCLES = 5000;
	localparam int unsigned HOLD_OFF_AT     = 40;
	localparam int unsigned RANDOM_WORDS    = 400;
	localparam int unsigned TAIL_CYCLES     = 50;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [nsr_pkg::RADICAND_W-1:0]  radicand;
	logic                            out_valid;
	logic                            out_ready;
	logic [nsr_pkg::ROOT_W-1:0]      root;
	logic [nsr_pkg::ITER_W-1:0]      iterations_used;
	logic                            converged;
	int                              pending_count;
	int                              fail_count;

	newton_square_root i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.radicand        (radicand),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.root            (root),
		.iterations_used (iterations_used),
		.converged       (converged)
	);

	nsr_root_monitor i_monitor (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.radicand        (radicand),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.root            (root),
		.iterations_used (iterations_used),
		.converged       (converged),
		.pending_count   (pending_count),
		.fail_count      (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Every input starts at a known value; reset is released once, on a
	// falling edge.
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		radicand  = '0;
		out_ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Idle cycles before the next word. Now and then a run of words with
	// no idling at all is started, so back-to-back traffic is covered too.
	function automatic int unsigned draw_gap(inout int unsigned steady_left);
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			steady_left = $urandom_range(5, 20);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// Random radicand, mostly spread over the interesting regions: full
	// range, small values, values around perfect squares (where truncation
	// can leave the estimate bouncing by one LSB), random bit lengths and
	// values close to the top of the range.
	function automatic logic [31:0] draw_radicand();
		int unsigned pick;
		logic [31:0] base;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			return $urandom;
		if (pick < 50)
			return $urandom_range(0, 1000);
		if (pick < 75) begin
			base = $urandom_range(1, 65535);
			base = base * base;
			case ($urandom_range(0, 2))
				0: return base - 32'd1;
				1: return base;
				default: return (base == 32'hFFFE_0001) ? base : base + 32'd1;
			endcase
		end
		if (pick < 90)
			return $urandom >> $urandom_range(0, 31);
		if ($urandom_range(0, 1) == 0)
			return 32'hFFFF_FFFF - $urandom_range(0, 255);
		return 32'd1 << $urandom_range(0, 31);
	endfunction

	int unsigned send_steady;

	// Offers one word and returns on the falling edge after it is taken.
	// When no gap is drawn, in_valid simply stays high for the next word.
	task automatic send_radicand(input logic [31:0] value);
		int unsigned gap;
		gap = draw_gap(send_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		radicand <= value;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Result side. After HOLD_OFF_AT words the receiver holds off for a
	// long stretch while the sender keeps offering, so the output register
	// fills, the next word finishes behind it and in_ready stays low.
	initial begin : receiver
		int unsigned recv_steady;
		int unsigned gap;
		int unsigned taken;
		recv_steady = 0;
		taken       = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (taken == HOLD_OFF_AT) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				gap = draw_gap(recv_steady);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
			taken++;
		end
	end

	// Ends the run when no word has moved on either channel for too long.
	initial begin : watchdog
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] directed_words[$];
		send_steady = 0;
		// Zero, the smallest radicands, powers of two and their neighbors,
		// perfect squares, alternating bit patterns and the top of the range.
		directed_words = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9,
			32'd15, 32'd16, 32'd255, 32'd256, 32'd65535, 32'd65536,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFE_0001, 32'hFFFF_FFFE,
			32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'd1000000,
			32'd999999, 32'd12345678};
		@(posedge arst_n);
		@(negedge clk);
		foreach (directed_words[i])
			send_radicand(directed_words[i]);
		repeat (RANDOM_WORDS)
			send_radicand(draw_radicand());
		in_valid <= 1'b0;
		// Drain the outstanding words, then let the block settle.
		while (pending_count != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/nsr_pkg.sv
rtl/nsr_div.sv
rtl/newton_square_root.sv
dv/nsr_root_monitor.sv
dv/tb_top.sv
